[rtl/ptc_pkg.sv]
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and codes of the push/pop trace classifier.
// ----------------------------------------------------------------------------
package ptc_pkg;

  // Operation carried by an input item
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } ptc_opcode_e;

  // Classification reported with every result item
  typedef enum logic [2:0] {
    VERDICT_IMPOSSIBLE = 3'd0,
    VERDICT_STACK      = 3'd1,
    VERDICT_QUEUE      = 3'd2,
    VERDICT_PRIORITY   = 3'd3,
    VERDICT_NOT_SURE   = 3'd4
  } ptc_verdict_e;

  // Bit positions of the per-discipline still-ok flags
  localparam int unsigned FLAG_STACK    = 0;
  localparam int unsigned FLAG_QUEUE    = 1;
  localparam int unsigned FLAG_PRIORITY = 2;

  // Per-cycle command broadcast to every sorted cell
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } ptc_cell_ctl_t;

  // Payload of one result item
  typedef struct packed {
    ptc_verdict_e verdict;
    logic         trace_done;
    logic         overflow;
  } ptc_result_t;

endpackage

[rtl/ptc_if.sv]
// ----------------------------------------------------------------------------
// ptc_if
// Valid/ready channels of the classifier: operation items in, results out.
// ----------------------------------------------------------------------------
interface ptc_op_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  import ptc_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic signed [VALUE_WIDTH-1:0] item_value;
  logic                          last_op;

  modport source (output valid, opcode, item_value, last_op, input ready);
  modport sink   (input valid, opcode, item_value, last_op, output ready);
endinterface

interface ptc_res_if;
  import ptc_pkg::*;

  logic         valid;
  logic         ready;
  ptc_verdict_e verdict;
  logic         trace_done;
  logic         overflow;

  modport source (output valid, verdict, trace_done, overflow, input ready);
  modport sink   (input valid, verdict, trace_done, overflow, output ready);
endinterface

[rtl/ptc_ram.sv]
// ----------------------------------------------------------------------------
// ptc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/ptc_cell.sv]
// ----------------------------------------------------------------------------
// ptc_cell
// One slot of the sorted chain: keeps one biased key and shifts it along.
// ----------------------------------------------------------------------------
module ptc_cell #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ptc_pkg::ptc_cell_ctl_t       ctl_i,
  input  logic [VALUE_WIDTH-1:0]       key_i,
  input  logic                         left_valid_i,
  input  logic [VALUE_WIDTH-1:0]       left_key_i,
  input  logic                         left_ge_i,
  input  logic                         right_valid_i,
  input  logic [VALUE_WIDTH-1:0]       right_key_i,
  output logic                         valid_o,
  output logic [VALUE_WIDTH-1:0]       key_o,
  output logic                         ge_o
);
  import ptc_pkg::*;

  logic                   valid_q, valid_d;
  logic [VALUE_WIDTH-1:0] key_q, key_d;

  // This cell stays put on a push when it holds a key not below the new one
  assign ge_o = valid_q && (key_q >= key_i);

  // Insert: take the new key if the left neighbor stays, else shift right.
  // Remove: take the right neighbor.
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    if (ctl_i.push && !ge_o) begin
      valid_d = left_ge_i | left_valid_i;
      key_d   = left_ge_i ? key_i : left_key_i;
    end else if (ctl_i.pop) begin
      valid_d = right_valid_i;
      key_d   = right_key_i;
    end
    if (ctl_i.clear) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;

endmodule

[rtl/ptc_pq.sv]
// ----------------------------------------------------------------------------
// ptc_pq
// Max-priority store as a row of sorted cells, largest key at cell 0.
// ----------------------------------------------------------------------------
module ptc_pq #(
  parameter int unsigned DEPTH       = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ptc_pkg::ptc_cell_ctl_t ctl_i,
  input  logic [VALUE_WIDTH-1:0] key_i,
  output logic                   head_valid_o,
  output logic [VALUE_WIDTH-1:0] head_key_o
);
  import ptc_pkg::*;

  logic                   cell_valid [DEPTH];
  logic [VALUE_WIDTH-1:0] cell_key   [DEPTH];
  logic                   cell_ge    [DEPTH];

  // Build the chain; the left edge offers the new key, the right edge is empty
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                   left_valid, left_ge, right_valid;
    logic [VALUE_WIDTH-1:0] left_key, right_key;

    if (i == 0) begin : g_first
      assign left_valid = 1'b1;
      assign left_key   = key_i;
      assign left_ge    = 1'b1;
    end else begin : g_inner
      assign left_valid = cell_valid[i-1];
      assign left_key   = cell_key[i-1];
      assign left_ge    = cell_ge[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_valid = 1'b0;
      assign right_key   = '0;
    end else begin : g_body
      assign right_valid = cell_valid[i+1];
      assign right_key   = cell_key[i+1];
    end

    ptc_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl_i),
      .key_i         (key_i),
      .left_valid_i  (left_valid),
      .left_key_i    (left_key),
      .left_ge_i     (left_ge),
      .right_valid_i (right_valid),
      .right_key_i   (right_key),
      .valid_o       (cell_valid[i]),
      .key_o         (cell_key[i]),
      .ge_o          (cell_ge[i])
    );
  end

  assign head_valid_o = cell_valid[0];
  assign head_key_o   = cell_key[0];

endmodule

[rtl/push_pop_trace_classifier.sv]
// ----------------------------------------------------------------------------
// push_pop_trace_classifier
// Judges a push/pop trace against stack, queue and max-priority disciplines.
// ----------------------------------------------------------------------------
// The block takes one operation item per clock while ready is high and
// returns one result item per operation through a four-entry output queue.
// The stack and the queue live in two RAMs (one access per item, read data
// registered); the priority store is a row of STORE_DEPTH sorted cells
// that insert or shift out. A pop is checked in the cycle after acceptance,
// when the RAM read data arrives. A stalled result side holds back input
// once four results wait in the output queue and the check stage together.
// The item that carries last_op closes the trace; the next item starts a
// fresh one with empty stores and all flags set.
// ----------------------------------------------------------------------------
module push_pop_trace_classifier #(
  parameter int unsigned STORE_DEPTH = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ptc_op_if.sink        op_i,
  ptc_res_if.source     res_o
);
  import ptc_pkg::*;

  localparam int unsigned AW     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned CW     = $clog2(STORE_DEPTH + 1);
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  // Check-stage control carried from acceptance to the compare cycle
  typedef struct packed {
    logic pop_chk;
    logic pop_empty;
    logic pq_miss;
    logic last;
    logic ovf;
  } chk_t;

  // --------------------------------------------------------------------------
  // Accept stage
  // --------------------------------------------------------------------------
  logic                   acc, is_pop, full, empty;
  logic [VALUE_WIDTH-1:0] val, key;
  logic [CW-1:0]          fill_q, fill_d;
  logic [AW-1:0]          head_q, head_d, tail_q, tail_d;
  logic                   ovf_q, ovf_d;
  ptc_cell_ctl_t          pq_ctl;
  logic                   pq_head_valid;
  logic [VALUE_WIDTH-1:0] pq_head_key;
  logic                   do_push, do_pop;
  logic [VALUE_WIDTH-1:0] lifo_rdata, fifo_rdata;

  assign acc    = op_i.valid && op_i.ready;
  assign is_pop = (op_i.opcode == OP_POP);
  assign val    = op_i.item_value;
  assign key    = val ^ (VALUE_WIDTH'(1) << (VALUE_WIDTH - 1));
  assign full   = (fill_q == CW'(STORE_DEPTH));
  assign empty  = (fill_q == '0);

  assign do_push = acc && !is_pop && !full;
  assign do_pop  = acc && is_pop && !empty;

  // Advance fill count and queue pointers; clear them at the end of a trace
  always_comb begin
    fill_d = fill_q;
    head_d = head_q;
    tail_d = tail_q;
    ovf_d  = ovf_q;
    if (do_push) begin
      fill_d = fill_q + CW'(1);
      tail_d = (tail_q == AW'(STORE_DEPTH - 1)) ? '0 : tail_q + AW'(1);
    end
    if (do_pop) begin
      fill_d = fill_q - CW'(1);
      head_d = (head_q == AW'(STORE_DEPTH - 1)) ? '0 : head_q + AW'(1);
    end
    if (acc && !is_pop && full) begin
      ovf_d = 1'b1;
    end
    if (acc && op_i.last_op) begin
      fill_d = '0;
      head_d = '0;
      tail_d = '0;
      ovf_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      head_q <= '0;
      tail_q <= '0;
      ovf_q  <= 1'b0;
    end else begin
      fill_q <= fill_d;
      head_q <= head_d;
      tail_q <= tail_d;
      ovf_q  <= ovf_d;
    end
  end

  // Stack: push writes at the fill level, pop reads the entry below it
  ptc_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_lifo_ram (
    .clk_i   (clk_i),
    .we_i    (do_push),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (val),
    .re_i    (do_pop),
    .raddr_i (AW'(fill_q - CW'(1))),
    .rdata_o (lifo_rdata)
  );

  // Queue: push writes at the tail, pop reads the head
  ptc_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (do_push),
    .waddr_i (tail_q),
    .wdata_i (val),
    .re_i    (do_pop),
    .raddr_i (head_q),
    .rdata_o (fifo_rdata)
  );

  // Priority store: sorted cells, largest key at the head
  assign pq_ctl.push  = do_push;
  assign pq_ctl.pop   = do_pop;
  assign pq_ctl.clear = acc && op_i.last_op;

  ptc_pq #(
    .DEPTH       (STORE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_pq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (pq_ctl),
    .key_i        (key),
    .head_valid_o (pq_head_valid),
    .head_key_o   (pq_head_key)
  );

  // --------------------------------------------------------------------------
  // Check stage
  // --------------------------------------------------------------------------
  logic                   chk_valid_q;
  chk_t                   chk_q;
  logic [VALUE_WIDTH-1:0] chk_val_q;
  logic [2:0]             flags_q, flags_now, fail;
  ptc_result_t            result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_valid_q <= 1'b0;
    end else begin
      chk_valid_q <= acc;
    end
  end

  // Capture what the compare cycle needs
  always_ff @(posedge clk_i) begin
    if (acc) begin
      chk_q.pop_chk   <= do_pop;
      chk_q.pop_empty <= is_pop && empty;
      chk_q.pq_miss   <= do_pop && (pq_head_key != key);
      chk_q.last      <= op_i.last_op;
      chk_q.ovf       <= ovf_q || (!is_pop && full);
      chk_val_q       <= val;
    end
  end

  // Drop flags on an empty pop or a wrong value
  always_comb begin
    fail[FLAG_STACK]    = chk_q.pop_empty || (chk_q.pop_chk && (lifo_rdata != chk_val_q));
    fail[FLAG_QUEUE]    = chk_q.pop_empty || (chk_q.pop_chk && (fifo_rdata != chk_val_q));
    fail[FLAG_PRIORITY] = chk_q.pop_empty || chk_q.pq_miss;
    flags_now           = flags_q & ~fail;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '1;
    end else if (chk_valid_q) begin
      flags_q <= chk_q.last ? '1 : flags_now;
    end
  end

  // Map the surviving flags to a verdict
  always_comb begin
    case (flags_now)
      3'b000:  result.verdict = VERDICT_IMPOSSIBLE;
      3'b001:  result.verdict = VERDICT_STACK;
      3'b010:  result.verdict = VERDICT_QUEUE;
      3'b100:  result.verdict = VERDICT_PRIORITY;
      default: result.verdict = VERDICT_NOT_SURE;
    endcase
    result.trace_done = chk_q.last;
    result.overflow   = chk_q.ovf;
  end

  // --------------------------------------------------------------------------
  // Output queue
  // --------------------------------------------------------------------------
  ptc_result_t    oq_mem_q [QDEPTH];
  logic [QAW-1:0] oq_wr_q, oq_rd_q;
  logic [QCW-1:0] oq_cnt_q;
  logic           oq_pop;

  assign oq_pop = res_o.valid && res_o.ready;

  always_ff @(posedge clk_i) begin
    if (chk_valid_q) begin
      oq_mem_q[oq_wr_q] <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (chk_valid_q) begin
        oq_wr_q <= oq_wr_q + QAW'(1);
      end
      if (oq_pop) begin
        oq_rd_q <= oq_rd_q + QAW'(1);
      end
      oq_cnt_q <= oq_cnt_q + QCW'(chk_valid_q) - QCW'(oq_pop);
    end
  end

  // Take a new item while the queue has room for everything in flight
  assign op_i.ready = (({1'b0, oq_cnt_q} + (QCW + 1)'(chk_valid_q)) < (QCW + 1)'(QDEPTH));

  assign res_o.valid      = (oq_cnt_q != '0);
  assign res_o.verdict    = oq_mem_q[oq_rd_q].verdict;
  assign res_o.trace_done = oq_mem_q[oq_rd_q].trace_done;
  assign res_o.overflow   = oq_mem_q[oq_rd_q].overflow;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_oq_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_cnt_q <= QCW'(QDEPTH))
    else $error("output queue overrun");

  a_pq_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pq_head_valid == (fill_q != '0))
    else $error("priority store occupancy differs from fill count");

  a_last_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && op_i.last_op) |=> (fill_q == '0) && !ovf_q)
    else $error("trace end did not clear the stores");

  a_ovf_set : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !is_pop && full && !op_i.last_op) |=> ovf_q && full)
    else $error("push on a full store not flagged");

endmodule
